>>> hdl/aseu_pkg.sv
// ----------------------------------------------------------------------------
// aseu_pkg
// Shared types, constants and the barrel shifter of the execute unit.
// ----------------------------------------------------------------------------
package aseu_pkg;

  localparam int MEM_WORDS = 16384;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) << 2;

  typedef enum logic [1:0] {
    KIND_DP   = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_XFER = 2'd2,
    KIND_BR   = 2'd3
  } kind_t;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] instr;
  } op_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [3:0]  flags;
    logic        wr;
    logic [3:0]  di;
    logic [31:0] dv;
    logic        merr;
  } res_t;

  // Returns {carry_out, value}.
  function automatic logic [32:0] shift_op(input logic [31:0] v, input logic [7:0] amt,
                                           input logic [1:0] sh, input logic cin);
    logic [63:0] t;
    logic [32:0] r;
    logic        big;
    t   = '0;
    r   = {cin, v};
    big = (amt[7:5] != 3'b000);
    if (amt != 8'd0) begin
      case (sh)
        SH_LSL: begin
          t = {32'b0, v} << amt[4:0];
          if (!big) r = {t[32], t[31:0]};
          else r = {(amt == 8'd32) ? v[0] : 1'b0, 32'b0};
        end
        SH_LSR: begin
          t = {v, 32'b0} >> amt[4:0];
          if (!big) r = {t[31], t[63:32]};
          else r = {(amt == 8'd32) ? v[31] : 1'b0, 32'b0};
        end
        SH_ASR: begin
          t = 64'($signed({v, 32'b0}) >>> amt[4:0]);
          if (!big) r = {t[31], t[63:32]};
          else r = {v[31], {32{v[31]}}};
        end
        default: begin
          t = {v, v} >> amt[4:0];
          r = {t[31], t[31:0]};
        end
      endcase
    end
    return r;
  endfunction

endpackage

>>> hdl/aseu_front.sv
// ----------------------------------------------------------------------------
// aseu_front
// Accepts instruction items, tags them by class and holds them in a
// two-entry queue for the execute back end.
// ----------------------------------------------------------------------------
module aseu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    kind,
  input  logic [31:0]   instruction,
  output logic          full,
  input  logic          clearing,
  output logic          hd_valid,
  output aseu_pkg::op_t hd,
  input  logic          hd_pop
);
  import aseu_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full     = clearing || (cnt == 2'd2);
  assign do_push  = push && !full;
  assign hd_valid = (cnt != 2'd0);
  assign do_pop   = hd_pop && hd_valid;
  assign hd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  // classify by the given kind code
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= '{kind: kind_t'(kind), instr: instruction};
    end
  end

endmodule

>>> hdl/aseu_back.sv
// ----------------------------------------------------------------------------
// aseu_back
// Executes queued instructions against the register file, flags, PC and
// data memory; clears the memory after reset.
// ----------------------------------------------------------------------------
module aseu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           hd_valid,
  input  aseu_pkg::op_t  hd,
  output logic           hd_pop,
  output logic           clearing,
  input  logic           out_room,
  output logic           emit,
  output aseu_pkg::res_t res
);
  import aseu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_EXEC, S_MUL, S_XFER, S_RDHI, S_FIN, S_WRHI
  } state_t;

  state_t      state, state_next;
  logic [31:0] rf [16];
  logic [3:0]  flags, flags_next;
  logic [31:0] pc, pc_next;
  logic [MEM_AW-1:0] clr_cnt;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic [MEM_AW-1:0] mem_addr;
  logic        mem_we;
  logic [31:0] mem_wd;

  // held instruction context
  logic [31:0] x_ins, x_ins_next;
  logic [31:0] x_addr, x_addr_next;
  logic [31:0] prod, prod_next;
  logic        x_wr, x_wr_next;
  logic [3:0]  x_di, x_di_next;
  logic [31:0] x_dv, x_dv_next;
  logic [31:0] lo, lo_next;

  logic        rf_we;
  logic [3:0]  rf_wi;
  logic [31:0] rf_wd;

  logic [31:0] ins;
  logic [3:0]  rn, rd, rm, rs, opc;
  logic [7:0]  shamt;
  logic [32:0] shr;
  logic [63:0] rot;
  logic [31:0] imm, op2, a, r, off, base, addr, nb;
  logic [32:0] diff, rdiff, sum;
  logic        keep;

  logic [MEM_AW-1:0] w;
  logic [1:0]  idx;
  logic [4:0]  lsh;
  logic [5:0]  hsh;
  logic        hasnext, oob;
  logic [31:0] lowmask, sdata, ldval;

  assign clearing = (state == S_CLEAR);

  always_comb begin
    ins   = (state == S_EXEC) ? hd.instr : x_ins;
    rn    = ins[19:16];
    rd    = ins[15:12];
    rm    = ins[3:0];
    rs    = ins[11:8];
    opc   = ins[24:21];
    shamt = ins[4] ? rf[rs][7:0] : {3'b000, ins[11:7]};
    shr   = shift_op(rf[rm], shamt, ins[6:5], flags[1]);
    rot   = {24'b0, ins[7:0], 24'b0, ins[7:0]} >> {ins[11:8], 1'b0};
    imm   = rot[31:0];
    a     = rf[rn];
    op2   = ins[25] ? imm : shr[31:0];
    diff  = {1'b0, a} - {1'b0, op2};
    rdiff = {1'b0, op2} - {1'b0, a};
    sum   = {1'b0, a} + {1'b0, op2};
    off   = ins[25] ? shr[31:0] : {20'b0, ins[11:0]};
    base  = (rn == 4'd15) ? ({a[29:0], 2'b00} + 32'd4) : a;
    addr  = ins[24] ? (ins[23] ? base + off : base - off) : base;
    nb    = ins[23] ? a + off : a - off;

    w       = x_addr[MEM_AW+1:2];
    idx     = x_addr[1:0];
    lsh     = {idx, 3'b000};
    hsh     = 6'd32 - {1'b0, lsh};
    hasnext = (w != MEM_AW'(MEM_WORDS - 1));
    oob     = ({1'b0, x_addr} >= MEM_BYTES);
    lowmask = ~(32'hFFFF_FFFF << lsh);
    sdata   = rf[x_ins[15:12]];
    ldval   = lo >> lsh;
    if (idx != 2'd0 && hasnext) ldval = ldval | (mem_q << hsh[4:0]);

    r = 32'b0;
    keep = 1'b1;
    case (opc)
      OP_AND, OP_TST: r = a & op2;
      OP_EOR, OP_TEQ: r = a ^ op2;
      OP_ORR:         r = a | op2;
      OP_MOV:         r = op2;
      OP_SUB, OP_CMP: r = diff[31:0];
      OP_RSB:         r = rdiff[31:0];
      OP_ADD:         r = sum[31:0];
      default:        keep = 1'b0;
    endcase

    state_next  = state;
    flags_next  = flags;
    pc_next     = pc;
    x_ins_next  = x_ins;
    x_addr_next = x_addr;
    prod_next   = prod;
    x_wr_next   = x_wr;
    x_di_next   = x_di;
    x_dv_next   = x_dv;
    lo_next     = lo;
    rf_we  = 1'b0;
    rf_wi  = 4'd0;
    rf_wd  = 32'b0;
    mem_we = 1'b0;
    mem_addr = w;
    mem_wd = 32'b0;
    hd_pop = 1'b0;
    emit   = 1'b0;
    res    = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        if (clr_cnt == MEM_AW'(MEM_WORDS - 1)) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (hd_valid && out_room) begin
          hd_pop     = 1'b1;
          x_ins_next = ins;
          unique case (hd.kind)
            KIND_DP: begin
              emit = 1'b1;
              if (keep) begin
                if (opc != OP_TST && opc != OP_TEQ && opc != OP_CMP) begin
                  rf_we = 1'b1;
                  rf_wi = rd;
                  rf_wd = r;
                  res.wr = 1'b1;
                  res.di = rd;
                  res.dv = r;
                end
                if (ins[20]) begin
                  flags_next[3] = r[31];
                  flags_next[2] = (r == 32'b0);
                  if (opc == OP_SUB || opc == OP_CMP) flags_next[1] = !diff[32];
                  else if (opc == OP_RSB) flags_next[1] = !rdiff[32];
                  else if (opc == OP_ADD) flags_next[1] = sum[32];
                  else if (!ins[25]) flags_next[1] = shr[32];
                end
              end
            end
            KIND_MUL: begin
              prod_next  = rf[rm] * rf[rs];
              state_next = S_MUL;
            end
            KIND_XFER: begin
              x_addr_next = addr;
              x_wr_next   = 1'b0;
              x_di_next   = 4'd0;
              x_dv_next   = 32'b0;
              if (!ins[24]) begin
                // post-index: write the base back now
                rf_we     = 1'b1;
                rf_wi     = rn;
                rf_wd     = nb;
                x_wr_next = 1'b1;
                x_di_next = rn;
                x_dv_next = nb;
              end
              state_next = S_XFER;
            end
            default: begin
              pc_next = pc + {{8{ins[23]}}, ins[23:0]} + 32'd1;
              emit    = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        rf_we = 1'b1;
        rf_wi = x_ins[19:16];
        rf_wd = prod + (x_ins[21] ? rf[x_ins[15:12]] : 32'b0);
        if (x_ins[20]) begin
          flags_next[3] = rf_wd[31];
          flags_next[2] = (rf_wd == 32'b0);
        end
        emit   = 1'b1;
        res.wr = 1'b1;
        res.di = rf_wi;
        res.dv = rf_wd;
        state_next = S_EXEC;
      end
      S_XFER: begin
        if (oob) begin
          emit     = 1'b1;
          res.merr = 1'b1;
          res.wr   = x_wr;
          res.di   = x_di;
          res.dv   = x_dv;
          state_next = S_EXEC;
        end else if (!x_ins[20] && idx == 2'd0) begin
          mem_we = 1'b1;
          mem_wd = sdata;
          emit   = 1'b1;
          res.wr = x_wr;
          res.di = x_di;
          res.dv = x_dv;
          state_next = S_EXEC;
        end else begin
          state_next = S_RDHI;
        end
      end
      S_RDHI: begin
        lo_next  = mem_q;
        mem_addr = hasnext ? w + MEM_AW'(1) : w;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (x_ins[20]) begin
          rf_we  = 1'b1;
          rf_wi  = x_ins[15:12];
          rf_wd  = ldval;
          emit   = 1'b1;
          res.wr = 1'b1;
          res.di = rf_wi;
          res.dv = ldval;
          state_next = S_EXEC;
        end else begin
          mem_we  = 1'b1;
          mem_wd  = (lo & lowmask) | (sdata << lsh);
          lo_next = (mem_q & ~lowmask) | (sdata >> hsh[4:0]);
          if (hasnext) begin
            state_next = S_WRHI;
          end else begin
            emit   = 1'b1;
            res.wr = x_wr;
            res.di = x_di;
            res.dv = x_dv;
            state_next = S_EXEC;
          end
        end
      end
      S_WRHI: begin
        mem_we   = 1'b1;
        mem_addr = w + MEM_AW'(1);
        mem_wd   = lo;
        emit   = 1'b1;
        res.wr = x_wr;
        res.di = x_di;
        res.dv = x_dv;
        state_next = S_EXEC;
      end
      default: state_next = S_EXEC;
    endcase

    res.pc    = pc_next;
    res.flags = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      flags   <= 4'd0;
      pc      <= 32'd0;
      for (int i = 0; i < 16; i++) rf[i] <= 32'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + MEM_AW'(1);
      flags <= flags_next;
      pc    <= pc_next;
      if (rf_we) rf[rf_wi] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    x_ins  <= x_ins_next;
    x_addr <= x_addr_next;
    prod   <= prod_next;
    x_wr   <= x_wr_next;
    x_di   <= x_di_next;
    x_dv   <= x_dv_next;
    lo     <= lo_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

endmodule

>>> hdl/aseu_outq.sv
// ----------------------------------------------------------------------------
// aseu_outq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module aseu_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           emit,
  input  aseu_pkg::res_t res,
  output logic           room,
  output logic           empty,
  input  logic           pop,
  output aseu_pkg::res_t head
);
  import aseu_pkg::*;

  res_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_pop;

  assign room   = (cnt != 2'd2);
  assign empty  = (cnt == 2'd0);
  assign do_pop = pop && !empty;
  assign head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (emit) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(emit) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) entries[wr_ptr] <= res;
  end

endmodule

>>> hdl/arm_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// arm_subset_execute_unit
// Executes pre-classified ARM-style instructions, one result per instruction.
// ----------------------------------------------------------------------------
// Input channel: drive kind/instruction with push; a transaction happens on a
// rising edge with push high and full low. Result channel: while empty is low
// the oldest result sits on the result ports; pop takes it.
// A two-entry instruction queue parts the front from the execute back end,
// and a two-entry result queue parts the back end from the result port.
// In the back end, data processing and branch finish in the execute state;
// multiply goes through a product register, then accumulate; loads and
// stores are stepped through the single data memory port (read low word,
// read high word, write low, write high).
// Reset: register file, flags and PC clear at once; then a clearing pass
// writes zero to all 16384 memory words, with full held high.
// When the receiver stalls, results collect in the result queue; once it is
// full the back end holds, and then the instruction queue fills and raises full.
module arm_subset_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [31:0] instruction,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] program_counter,
  output logic [3:0]  flags_nzcv,
  output logic        reg_written,
  output logic [3:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        mem_error
);
  import aseu_pkg::*;

  logic clearing;
  logic hd_valid;
  op_t  hd;
  logic hd_pop;
  logic out_room;
  logic emit;
  res_t res;
  res_t head;

  // accept and queue instructions
  aseu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .kind        (kind),
    .instruction (instruction),
    .full        (full),
    .clearing    (clearing),
    .hd_valid    (hd_valid),
    .hd          (hd),
    .hd_pop      (hd_pop)
  );

  // execute against architectural state and memory
  aseu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .hd_valid (hd_valid),
    .hd       (hd),
    .hd_pop   (hd_pop),
    .clearing (clearing),
    .out_room (out_room),
    .emit     (emit),
    .res      (res)
  );

  // hold results until popped
  aseu_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .res   (res),
    .room  (out_room),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign program_counter = head.pc;
  assign flags_nzcv      = head.flags;
  assign reg_written     = head.wr;
  assign dest_index      = head.di;
  assign dest_value      = head.dv;
  assign mem_error       = head.merr;

endmodule

>>> hdl/aseu_checker.sv
// ----------------------------------------------------------------------------
// aseu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module aseu_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] program_counter,
  input logic        reg_written,
  input logic [3:0]  dest_index,
  input logic [31:0] dest_value
);

  // hold off input while memory clears after reset
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("full not raised after reset");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // no register write means a zero index and value
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !reg_written) |-> (dest_index == 4'd0 && dest_value == 32'd0))
    else $error("dest fields set without a register write");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(program_counter)))
    else $error("stalled result changed");

endmodule

bind arm_subset_execute_unit aseu_checker u_aseu_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .program_counter (program_counter),
  .reg_written     (reg_written),
  .dest_index      (dest_index),
  .dest_value      (dest_value)
);
